[hw/rtl/iratd_pkg.sv]
// Shared types and constants for the IR proximity / ambient / trend detector.
// No dependencies; every other file refers to it by scoped names.
package iratd_pkg;

  // Default parameter values
  localparam int HISTORY_DEPTH_DEF = 4;
  localparam int SAMPLE_BITS_DEF   = 12;

  // Corrected readings
  localparam int LVL_W   = 14;
  localparam int LVL_MAX = 8191;
  localparam int LVL_MIN = -8192;

  // Configuration register file
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int OFS_W    = 12;
  localparam int PHASE_W  = 4;
  localparam logic [OFS_W-1:0]   RELEASE_RESET     = 12'd700;
  localparam logic [PHASE_W-1:0] PHASE_LIMIT_RESET = 4'd6;

  typedef enum logic [2:0] {
    REG_XP_OFS      = 3'd0,
    REG_LWALL_OFS   = 3'd1,
    REG_RWALL_OFS   = 3'd2,
    REG_RELEASE     = 3'd3,
    REG_PHASE_LIMIT = 3'd4
  } cfg_reg_t;

  // Input item kinds
  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  // Reading slots in ambient and corrected stores
  typedef enum logic [2:0] {
    LV_FRONT = 3'd0,
    LV_LEFT  = 3'd1,
    LV_RIGHT = 3'd2,
    LV_LWALL = 3'd3,
    LV_RWALL = 3'd4,
    LV_AUX   = 3'd5
  } lvl_idx_t;
  localparam int LV_COUNT = 6;

  // Emitter mask: bit0 ch1, bit1 ch2, bit2 ch3, bit3 ch4, bit4 wall
  localparam int EM_W = 5;
  localparam logic [EM_W-1:0] EM_G1_SET = 5'h13;
  localparam logic [EM_W-1:0] EM_G1_CLR = 5'h0C;
  localparam logic [EM_W-1:0] EM_G0_SET = 5'h0C;
  localparam logic [EM_W-1:0] EM_G0_CLR = 5'h03;

  // Control for one history line
  typedef struct packed {
    logic shift;      // push the new reading this cycle
    logic post_view;  // compare against the line as it stands after the push
  } hist_ctl_t;

endpackage

[hw/rtl/iratd_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on iratd_pkg.
interface iratd_in_if #(
  parameter int SAMPLE_BITS = iratd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] sample_ch1;
  logic [SAMPLE_BITS-1:0] sample_ch2;
  logic [SAMPLE_BITS-1:0] sample_ch3;
  logic [SAMPLE_BITS-1:0] sample_aux;

  modport source (output valid, kind, sample_ch1, sample_ch2, sample_ch3, sample_aux,
                  input ready);
  modport sink   (input valid, kind, sample_ch1, sample_ch2, sample_ch3, sample_aux,
                  output ready);
endinterface

interface iratd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                near;
  logic signed [iratd_pkg::LVL_W-1:0]  front_level;
  logic signed [iratd_pkg::LVL_W-1:0]  left_level;
  logic signed [iratd_pkg::LVL_W-1:0]  right_level;
  logic signed [iratd_pkg::LVL_W-1:0]  left_wall_level;
  logic signed [iratd_pkg::LVL_W-1:0]  right_wall_level;
  logic signed [iratd_pkg::LVL_W-1:0]  aux_wall_level;
  logic [iratd_pkg::EM_W-1:0]          emitter_mask;

  modport source (output valid, near, front_level, left_level, right_level,
                         left_wall_level, right_wall_level, aux_wall_level, emitter_mask,
                  input ready);
  modport sink   (input valid, near, front_level, left_level, right_level,
                        left_wall_level, right_wall_level, aux_wall_level, emitter_mask,
                  output ready);
endinterface

[hw/rtl/iratd_hist_cell.sv]
// One history slot: holds a reading, shifts from its upstream neighbor and
// extends the strict-rise compare chain. Depends on iratd_pkg.
module iratd_hist_cell #(
  parameter int W = iratd_pkg::LVL_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iratd_pkg::hist_ctl_t ctl,
  input  logic signed [W-1:0]  d_in,
  input  logic signed [W-1:0]  up_view,
  input  logic                 rise_in,
  output logic signed [W-1:0]  q,
  output logic signed [W-1:0]  view,
  output logic                 rise_out
);

  logic signed [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctl.shift) begin
      q_r <= d_in;
    end
  end

  assign q        = q_r;
  assign view     = (ctl.post_view && ctl.shift) ? d_in : q_r;
  assign rise_out = rise_in && (up_view > view);

endmodule

[hw/rtl/iratd_hist_line.sv]
// History line built as a row of iratd_hist_cell; reports a strict rise
// through all entries, oldest first, to the current reading. Depends on iratd_pkg.
module iratd_hist_line #(
  parameter int DEPTH = iratd_pkg::HISTORY_DEPTH_DEF,
  parameter int W     = iratd_pkg::LVL_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iratd_pkg::hist_ctl_t ctl,
  input  logic signed [W-1:0]  din,
  input  logic signed [W-1:0]  cur,
  output logic                 rising
);

  logic signed [W-1:0] q_w    [DEPTH];
  logic signed [W-1:0] view_w [DEPTH];
  logic                rise_w [DEPTH+1];

  assign rise_w[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [W-1:0] d_in_w;
    logic signed [W-1:0] up_w;
    if (i == 0) begin : g_head
      assign d_in_w = din;
      assign up_w   = cur;
    end else begin : g_body
      assign d_in_w = q_w[i-1];
      assign up_w   = view_w[i-1];
    end
    iratd_hist_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .d_in     (d_in_w),
      .up_view  (up_w),
      .rise_in  (rise_w[i]),
      .q        (q_w[i]),
      .view     (view_w[i]),
      .rise_out (rise_w[i+1])
    );
  end

  assign rising = rise_w[DEPTH];

endmodule

[hw/rtl/ir_proximity_ambient_trend_detect_top.sv]
// Top level of the IR proximity front end: config registers, ambient capture,
// correction, near flag, phase counter and output register.
// Depends on iratd_pkg, iratd_if, iratd_hist_line.
//
//  port    | dir | kind        | contents
//  --------+-----+-------------+-------------------------------------------
//  in_ch   | in  | valid/ready | kind, four samples
//  out_ch  | out | valid/ready | near, six corrected levels, emitter mask
//  psel..  | in  | APB         | five config registers at 4*index
//
// One transfer per cycle in and out unless the output stalls; every item updates
// state when taken; its result is in the output register from the next cycle on.
// A stalled result holds the register; the input is taken again as soon as
// the register is read in the same cycle, so a stall costs only its own cycles.
// Sync active-low reset clears all state but output data, loads reg defaults.
module ir_proximity_ambient_trend_detect_top #(
  parameter int HISTORY_DEPTH = iratd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = iratd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  iratd_in_if.sink                          in_ch,
  iratd_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iratd_pkg::CFG_AW-1:0]      paddr,
  input  logic [iratd_pkg::CFG_DW-1:0]      pwdata,
  output logic [iratd_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int LW = iratd_pkg::LVL_W;
  localparam int OW = iratd_pkg::OFS_W;
  localparam int PW = iratd_pkg::PHASE_W;
  localparam int EW = iratd_pkg::EM_W;
  localparam int SB = SAMPLE_BITS;
  localparam int DW = ((SB > OW) ? SB : OW) + 2;
  localparam logic signed [DW-1:0] SAT_HI = DW'(iratd_pkg::LVL_MAX);
  localparam logic signed [DW-1:0] SAT_LO = DW'(iratd_pkg::LVL_MIN);

  function automatic logic signed [LW-1:0] sat_level(input logic signed [DW-1:0] v);
    logic signed [LW-1:0] r;
    if (v > SAT_HI) begin
      r = LW'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = LW'(SAT_LO);
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [OW-1:0] xp_ofs_r, lwall_ofs_r, rwall_ofs_r, release_r;
  logic [PW-1:0] phase_limit_r;
  logic          cfg_wr;
  iratd_pkg::cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = iratd_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xp_ofs_r      <= '0;
      lwall_ofs_r   <= '0;
      rwall_ofs_r   <= '0;
      release_r     <= iratd_pkg::RELEASE_RESET;
      phase_limit_r <= iratd_pkg::PHASE_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        iratd_pkg::REG_XP_OFS:      xp_ofs_r      <= pwdata[OW-1:0];
        iratd_pkg::REG_LWALL_OFS:   lwall_ofs_r   <= pwdata[OW-1:0];
        iratd_pkg::REG_RWALL_OFS:   rwall_ofs_r   <= pwdata[OW-1:0];
        iratd_pkg::REG_RELEASE:     release_r     <= pwdata[OW-1:0];
        iratd_pkg::REG_PHASE_LIMIT: phase_limit_r <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      iratd_pkg::REG_XP_OFS:      prdata = 32'(xp_ofs_r);
      iratd_pkg::REG_LWALL_OFS:   prdata = 32'(lwall_ofs_r);
      iratd_pkg::REG_RWALL_OFS:   prdata = 32'(rwall_ofs_r);
      iratd_pkg::REG_RELEASE:     prdata = 32'(release_r);
      iratd_pkg::REG_PHASE_LIMIT: prdata = 32'(phase_limit_r);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  logic                 run_r, run_nxt;
  logic                 grp_r, grp_nxt;
  logic [PW-1:0]        phase_r, phase_nxt;
  logic                 near_r, near_nxt;
  logic [EW-1:0]        emit_r, emit_nxt;
  logic [SB-1:0]        amb_r   [iratd_pkg::LV_COUNT];
  logic [SB-1:0]        amb_nxt [iratd_pkg::LV_COUNT];
  logic signed [LW-1:0] cs_r    [iratd_pkg::LV_COUNT];
  logic signed [LW-1:0] cs_nxt  [iratd_pkg::LV_COUNT];

  logic                 out_vld_r;
  logic                 acc, is_on, on_run;
  logic [PW:0]          phase_inc;
  logic                 rise_f, rise_l, rise_r;
  logic signed [LW-1:0] rel_s;

  logic signed [DW-1:0] c1_s, c2_s, c3_s, ca_s;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_on       = (in_ch.kind == iratd_pkg::KIND_ON);
  assign on_run      = acc && is_on && run_r;

  assign c1_s  = signed'(DW'(in_ch.sample_ch1));
  assign c2_s  = signed'(DW'(in_ch.sample_ch2));
  assign c3_s  = signed'(DW'(in_ch.sample_ch3));
  assign ca_s  = signed'(DW'(in_ch.sample_aux));
  assign rel_s = signed'(LW'(release_r));
  assign phase_inc = {1'b0, phase_r} + (PW+1)'(1);

  always_comb begin
    run_nxt   = run_r;
    grp_nxt   = grp_r;
    phase_nxt = phase_r;
    emit_nxt  = emit_r;
    amb_nxt   = amb_r;
    cs_nxt    = cs_r;

    if (on_run) begin
      run_nxt = 1'b0;
      cs_nxt[iratd_pkg::LV_FRONT] =
        sat_level(c2_s - signed'(DW'(amb_r[iratd_pkg::LV_FRONT])));
      if (grp_r) begin
        cs_nxt[iratd_pkg::LV_AUX] = sat_level(ca_s
          - signed'(DW'(amb_r[iratd_pkg::LV_AUX])) - signed'(DW'(xp_ofs_r)));
        cs_nxt[iratd_pkg::LV_LWALL] = sat_level(c1_s
          - signed'(DW'(amb_r[iratd_pkg::LV_LWALL])) - signed'(DW'(lwall_ofs_r)));
        cs_nxt[iratd_pkg::LV_RIGHT] =
          sat_level(c3_s - signed'(DW'(amb_r[iratd_pkg::LV_RIGHT])));
      end else begin
        cs_nxt[iratd_pkg::LV_LEFT] =
          sat_level(c1_s - signed'(DW'(amb_r[iratd_pkg::LV_LEFT])));
        cs_nxt[iratd_pkg::LV_RWALL] = sat_level(c3_s
          - signed'(DW'(amb_r[iratd_pkg::LV_RWALL])) - signed'(DW'(rwall_ofs_r)));
      end
    end

    if (acc && is_on) begin
      if (phase_inc > {1'b0, phase_limit_r}) begin
        phase_nxt = '0;
        run_nxt   = 1'b1;
        grp_nxt   = !grp_r;
        if (!grp_r) begin
          emit_nxt = (emit_r & ~iratd_pkg::EM_G1_CLR) | iratd_pkg::EM_G1_SET;
        end else begin
          emit_nxt = (emit_r & ~iratd_pkg::EM_G0_CLR) | iratd_pkg::EM_G0_SET;
        end
      end else begin
        phase_nxt = phase_inc[PW-1:0];
      end
    end

    // Emitter-off: drop all emitters, capture ambient for the active group if a run is pending
    if (acc && !is_on) begin
      emit_nxt = '0;
      if (run_r) begin
        amb_nxt[iratd_pkg::LV_FRONT] = in_ch.sample_ch2;
        if (grp_r) begin
          amb_nxt[iratd_pkg::LV_AUX]   = in_ch.sample_aux;
          amb_nxt[iratd_pkg::LV_LWALL] = in_ch.sample_ch1;
          amb_nxt[iratd_pkg::LV_RIGHT] = in_ch.sample_ch3;
        end else begin
          amb_nxt[iratd_pkg::LV_LEFT]  = in_ch.sample_ch1;
          amb_nxt[iratd_pkg::LV_RWALL] = in_ch.sample_ch3;
        end
      end
    end
  end

  // Near flag, on each measured reading: any rising trend sets it, all three low clears it
  always_comb begin
    near_nxt = near_r;
    if (on_run) begin
      if (rise_f || rise_l || rise_r) begin
        near_nxt = 1'b1;
      end else if (cs_nxt[iratd_pkg::LV_LEFT] < rel_s &&
                   cs_nxt[iratd_pkg::LV_FRONT] < rel_s &&
                   cs_nxt[iratd_pkg::LV_RIGHT] < rel_s) begin
        near_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      grp_r   <= 1'b0;
      phase_r <= '0;
      near_r  <= 1'b0;
      emit_r  <= '0;
      for (int i = 0; i < iratd_pkg::LV_COUNT; i++) begin
        amb_r[i] <= '0;
        cs_r[i]  <= '0;
      end
    end else begin
      run_r   <= run_nxt;
      grp_r   <= grp_nxt;
      phase_r <= phase_nxt;
      near_r  <= near_nxt;
      emit_r  <= emit_nxt;
      amb_r   <= amb_nxt;
      cs_r    <= cs_nxt;
    end
  end

  // ---------------- history lines ----------------
  iratd_pkg::hist_ctl_t ctl_f, ctl_l, ctl_r;

  assign ctl_f = '{shift: on_run,           post_view: 1'b0};
  assign ctl_l = '{shift: on_run && !grp_r, post_view: 1'b1};
  assign ctl_r = '{shift: on_run && grp_r,  post_view: 1'b1};

  iratd_hist_line #(.DEPTH(HISTORY_DEPTH), .W(LW)) u_front_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_f),
    .din    (cs_nxt[iratd_pkg::LV_FRONT]),
    .cur    (cs_nxt[iratd_pkg::LV_FRONT]),
    .rising (rise_f)
  );

  iratd_hist_line #(.DEPTH(HISTORY_DEPTH), .W(LW)) u_left_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_l),
    .din    (cs_nxt[iratd_pkg::LV_LEFT]),
    .cur    (cs_nxt[iratd_pkg::LV_LEFT]),
    .rising (rise_l)
  );

  iratd_hist_line #(.DEPTH(HISTORY_DEPTH), .W(LW)) u_right_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_r),
    .din    (cs_nxt[iratd_pkg::LV_RIGHT]),
    .cur    (cs_nxt[iratd_pkg::LV_RIGHT]),
    .rising (rise_r)
  );

  // ---------------- output register ----------------
  logic                 near_o_r;
  logic signed [LW-1:0] lvl_o_r [iratd_pkg::LV_COUNT];
  logic [EW-1:0]        emit_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (acc) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      near_o_r <= near_nxt;
      lvl_o_r  <= cs_nxt;
      emit_o_r <= emit_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.near             = near_o_r;
  assign out_ch.front_level      = lvl_o_r[iratd_pkg::LV_FRONT];
  assign out_ch.left_level       = lvl_o_r[iratd_pkg::LV_LEFT];
  assign out_ch.right_level      = lvl_o_r[iratd_pkg::LV_RIGHT];
  assign out_ch.left_wall_level  = lvl_o_r[iratd_pkg::LV_LWALL];
  assign out_ch.right_wall_level = lvl_o_r[iratd_pkg::LV_RWALL];
  assign out_ch.aux_wall_level   = lvl_o_r[iratd_pkg::LV_AUX];
  assign out_ch.emitter_mask     = emit_o_r;

  // ---------------- assertions ----------------
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_vld_r)
    else $error("accepted item produced no result");

  a_groups_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_r[0] && emit_r[2]))
    else $error("ch1 and ch3 emitters on together");

  a_switch_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_r != $past(grp_r)) |-> (phase_r == '0 && run_r))
    else $error("group switched without phase wrap");

  a_ambient_only_off: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_on) |=> $stable(amb_r[iratd_pkg::LV_FRONT]))
    else $error("ambient changed on emitter-on item");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for ir_proximity_ambient_trend_detect_top: directed and random sensor frames
// with a cycle-free predictor of levels, near flag and emitter mask; APB register checks.
// Depends on iratd_pkg, iratd_if and the RTL top level.
module testbench;

  localparam int SB          = iratd_pkg::SAMPLE_BITS_DEF;
  localparam int HD          = iratd_pkg::HISTORY_DEPTH_DEF;
  localparam int NLV         = iratd_pkg::LV_COUNT;
  localparam int LW          = iratd_pkg::LVL_W;
  localparam int EW          = iratd_pkg::EM_W;
  localparam int AW          = iratd_pkg::CFG_AW;
  localparam int CDW         = iratd_pkg::CFG_DW;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 100;

  typedef logic [3:0][SB-1:0] sample_set_t;  // ch1, ch2, ch3, aux
  typedef struct packed {
    logic                    near;
    logic [NLV-1:0][LW-1:0]  lvl;
    logic [EW-1:0]           em;
  } readout_t;
  typedef enum {TR_MIXED, TR_APPROACH, TR_RETREAT} trend_t;

  logic           clk;
  logic           rst_n;
  logic           psel, penable, pwrite;
  logic [AW-1:0]  paddr;
  logic [CDW-1:0] pwdata, prdata;
  logic           pready;

  iratd_in_if #(.SAMPLE_BITS(SB)) in_bus ();
  iratd_out_if out_bus ();

  ir_proximity_ambient_trend_detect_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copies
  int xp_ofs = 0, lwall_ofs = 0, rwall_ofs = 0, rel_lvl = 700, ph_lim = 6;
  // sensor state copies
  bit       run_pend = 1'b0, grp_sel = 1'b0, near_q = 1'b0;
  int       phase_cnt = 0;
  logic [EW-1:0] em_q = '0;
  int       amb_store[NLV] = '{default: 0};
  int       lvl_store[NLV] = '{default: 0};
  int       hist_front[HD] = '{default: 0};
  int       hist_left[HD]  = '{default: 0};
  int       hist_right[HD] = '{default: 0};

  readout_t expected_readouts[$];
  int       errors = 0;
  int       sent_items = 0;
  bit       calm = 1'b0;
  string    lvl_name[NLV] = '{"front_level", "left_level", "right_level",
                              "left_wall_level", "right_wall_level", "aux_wall_level"};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always begin
    out_bus.ready <= calm || ($urandom_range(99) >= 20);
    @(posedge clk);
  end

  function automatic int clamp_level(input int v);
    if (v > iratd_pkg::LVL_MAX) return iratd_pkg::LVL_MAX;
    if (v < iratd_pkg::LVL_MIN) return iratd_pkg::LVL_MIN;
    return v;
  endfunction

  function automatic bit trend_rising(input int h[HD], input int cur);
    bit ok;
    ok = cur > h[0];
    for (int i = 0; i + 1 < HD; i++)
      if (!(h[i] > h[i + 1])) ok = 1'b0;
    return ok;
  endfunction

  function automatic void shift_in(inout int h[HD], input int v);
    for (int i = HD - 1; i > 0; i--) h[i] = h[i - 1];
    h[0] = v;
  endfunction

  function automatic readout_t predict_readout(input logic kind, input sample_set_t s);
    readout_t r;
    int c1, c2, c3, ca, nxt;
    c1 = int'(s[0]);
    c2 = int'(s[1]);
    c3 = int'(s[2]);
    ca = int'(s[3]);
    if (kind == iratd_pkg::KIND_ON) begin
      if (run_pend) begin
        run_pend = 1'b0;
        lvl_store[iratd_pkg::LV_FRONT] = clamp_level(c2 - amb_store[iratd_pkg::LV_FRONT]);
        if (grp_sel) begin
          lvl_store[iratd_pkg::LV_AUX] =
            clamp_level(ca - amb_store[iratd_pkg::LV_AUX] - xp_ofs);
          lvl_store[iratd_pkg::LV_LWALL] =
            clamp_level(c1 - amb_store[iratd_pkg::LV_LWALL] - lwall_ofs);
          lvl_store[iratd_pkg::LV_RIGHT] =
            clamp_level(c3 - amb_store[iratd_pkg::LV_RIGHT]);
          shift_in(hist_right, lvl_store[iratd_pkg::LV_RIGHT]);
        end else begin
          lvl_store[iratd_pkg::LV_LEFT] =
            clamp_level(c1 - amb_store[iratd_pkg::LV_LEFT]);
          lvl_store[iratd_pkg::LV_RWALL] =
            clamp_level(c3 - amb_store[iratd_pkg::LV_RWALL] - rwall_ofs);
          shift_in(hist_left, lvl_store[iratd_pkg::LV_LEFT]);
        end
        // front is tested against its line before this reading is pushed
        if (trend_rising(hist_front, lvl_store[iratd_pkg::LV_FRONT]) ||
            trend_rising(hist_left, lvl_store[iratd_pkg::LV_LEFT]) ||
            trend_rising(hist_right, lvl_store[iratd_pkg::LV_RIGHT])) begin
          near_q = 1'b1;
        end else if (lvl_store[iratd_pkg::LV_LEFT] < rel_lvl &&
                     lvl_store[iratd_pkg::LV_FRONT] < rel_lvl &&
                     lvl_store[iratd_pkg::LV_RIGHT] < rel_lvl) begin
          near_q = 1'b0;
        end
        shift_in(hist_front, lvl_store[iratd_pkg::LV_FRONT]);
      end
      nxt = phase_cnt + 1;
      if (nxt > ph_lim) begin
        phase_cnt = 0;
        run_pend  = 1'b1;
        grp_sel   = !grp_sel;
        if (grp_sel) em_q = (em_q & ~iratd_pkg::EM_G1_CLR) | iratd_pkg::EM_G1_SET;
        else em_q = (em_q & ~iratd_pkg::EM_G0_CLR) | iratd_pkg::EM_G0_SET;
      end else begin
        phase_cnt = nxt;
      end
    end else begin
      em_q = '0;
      if (run_pend) begin
        amb_store[iratd_pkg::LV_FRONT] = c2;
        if (grp_sel) begin
          amb_store[iratd_pkg::LV_AUX]   = ca;
          amb_store[iratd_pkg::LV_LWALL] = c1;
          amb_store[iratd_pkg::LV_RIGHT] = c3;
        end else begin
          amb_store[iratd_pkg::LV_LEFT]  = c1;
          amb_store[iratd_pkg::LV_RWALL] = c3;
        end
      end
    end
    r.near = near_q;
    for (int j = 0; j < NLV; j++) r.lvl[j] = lvl_store[j][LW-1:0];
    r.em = em_q;
    return r;
  endfunction

  function automatic int shadow_of(input iratd_pkg::cfg_reg_t idx);
    case (idx)
      iratd_pkg::REG_XP_OFS:      return xp_ofs;
      iratd_pkg::REG_LWALL_OFS:   return lwall_ofs;
      iratd_pkg::REG_RWALL_OFS:   return rwall_ofs;
      iratd_pkg::REG_RELEASE:     return rel_lvl;
      iratd_pkg::REG_PHASE_LIMIT: return ph_lim;
      default:                    return 0;
    endcase
  endfunction

  function automatic sample_set_t random_samples();
    sample_set_t s;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(9))
        0:       s[k] = '0;
        1:       s[k] = '1;
        default: s[k] = SB'($urandom_range(4095));
      endcase
    end
    return s;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
    errors++;
  endtask

  task automatic check_readout();
    readout_t got, want;
    got.near                        = out_bus.near;
    got.lvl[iratd_pkg::LV_FRONT]    = out_bus.front_level;
    got.lvl[iratd_pkg::LV_LEFT]     = out_bus.left_level;
    got.lvl[iratd_pkg::LV_RIGHT]    = out_bus.right_level;
    got.lvl[iratd_pkg::LV_LWALL]    = out_bus.left_wall_level;
    got.lvl[iratd_pkg::LV_RWALL]    = out_bus.right_wall_level;
    got.lvl[iratd_pkg::LV_AUX]      = out_bus.aux_wall_level;
    got.em                          = out_bus.emitter_mask;
    if (expected_readouts.size() == 0) begin
      report_mismatch("result transfer with nothing expected", 1, 0);
    end else begin
      want = expected_readouts.pop_front();
      if (got.near !== want.near) report_mismatch("near", int'(got.near), int'(want.near));
      for (int j = 0; j < NLV; j++)
        if (got.lvl[j] !== want.lvl[j])
          report_mismatch(lvl_name[j], int'($signed(got.lvl[j])), int'($signed(want.lvl[j])));
      if (got.em !== want.em) report_mismatch("emitter_mask", int'(got.em), int'(want.em));
    end
  endtask

  // predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      expected_readouts.push_back(predict_readout(in_bus.kind, {in_bus.sample_aux,
        in_bus.sample_ch3, in_bus.sample_ch2, in_bus.sample_ch1}));
    if (rst_n && out_bus.valid && out_bus.ready) check_readout();
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_frame(input logic kind, input sample_set_t s);
    while (!calm && $urandom_range(99) < 20) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= kind;
    in_bus.sample_ch1 <= s[0];
    in_bus.sample_ch2 <= s[1];
    in_bus.sample_ch3 <= s[2];
    in_bus.sample_aux <= s[3];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_items++;
  endtask

  // ambient capture, lit compare, then filler events up to the next group switch
  task automatic measure_run(input sample_set_t amb, input sample_set_t lit);
    send_frame(iratd_pkg::KIND_OFF, amb);
    send_frame(iratd_pkg::KIND_ON, lit);
    repeat (ph_lim) send_frame(iratd_pkg::KIND_ON, random_samples());
  endtask

  task automatic settle_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_register(input iratd_pkg::cfg_reg_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AW'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CDW'(shadow_of(idx)))
      report_mismatch("register readback", int'(prdata), shadow_of(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_register(input iratd_pkg::cfg_reg_t idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4 * int'(idx));
    pwdata  <= CDW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      iratd_pkg::REG_XP_OFS:      xp_ofs    = val & 12'hFFF;
      iratd_pkg::REG_LWALL_OFS:   lwall_ofs = val & 12'hFFF;
      iratd_pkg::REG_RWALL_OFS:   rwall_ofs = val & 12'hFFF;
      iratd_pkg::REG_RELEASE:     rel_lvl   = val & 12'hFFF;
      iratd_pkg::REG_PHASE_LIMIT: ph_lim    = val & 4'hF;
      default: ;
    endcase
    check_register(idx);
  endtask

  task automatic apply_settings(input int xp, input int lw, input int rw, input int rel,
                                input int lim);
    settle_idle();
    program_register(iratd_pkg::REG_XP_OFS, xp);
    program_register(iratd_pkg::REG_LWALL_OFS, lw);
    program_register(iratd_pkg::REG_RWALL_OFS, rw);
    program_register(iratd_pkg::REG_RELEASE, rel);
    program_register(iratd_pkg::REG_PHASE_LIMIT, lim);
  endtask

  task automatic test_register_defaults();
    check_register(iratd_pkg::REG_XP_OFS);
    check_register(iratd_pkg::REG_LWALL_OFS);
    check_register(iratd_pkg::REG_RWALL_OFS);
    check_register(iratd_pkg::REG_RELEASE);
    check_register(iratd_pkg::REG_PHASE_LIMIT);
  endtask

  // five strictly rising runs set near; two quiet runs clear it
  task automatic test_approach_ramp();
    apply_settings(0, 0, 0, 700, 1);
    send_frame(iratd_pkg::KIND_OFF, random_samples());  // no run pending: capture is dropped
    repeat (2) send_frame(iratd_pkg::KIND_ON, random_samples());
    for (int k = 1; k <= 5; k++) measure_run('0, {4{SB'(600 + 350 * k)}});
    repeat (2) measure_run('0, {4{SB'(10)}});
  endtask

  task automatic test_level_extremes();
    apply_settings(4095, 4095, 4095, 700, 1);
    measure_run('1, '0);
    measure_run('1, '0);
    apply_settings(0, 0, 0, 4095, 1);
    measure_run('0, '1);
    measure_run('0, '1);
  endtask

  task automatic test_random_traffic();
    sample_set_t amb, lit;
    trend_t      trend;
    int          ramp, retreat_left, target, pick;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, 0, 1);
        1: apply_settings(4095, 4095, 4095, 4095, 15);
        2: apply_settings($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(1, 15));
        default: apply_settings($urandom_range(600), $urandom_range(600), $urandom_range(600),
                                $urandom_range(300, 1500), $urandom_range(1, 4));
      endcase
      calm         = (p == 1);
      trend        = TR_APPROACH;
      ramp         = $urandom_range(1, 200);
      retreat_left = 0;
      target       = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          case (trend)
            TR_APPROACH: begin
              for (int k = 0; k < 4; k++) begin
                amb[k] = SB'($urandom_range(300));
                lit[k] = amb[k] + SB'(ramp);
              end
              ramp += $urandom_range(50, 400);
              if (ramp > 3500) begin
                trend        = TR_RETREAT;
                retreat_left = 3;
              end
            end
            TR_RETREAT: begin
              for (int k = 0; k < 4; k++) begin
                amb[k] = SB'($urandom_range(300));
                lit[k] = amb[k] + SB'($urandom_range(50));
              end
              retreat_left--;
              if (retreat_left == 0) trend = TR_MIXED;
            end
            default: begin
              amb = random_samples();
              lit = random_samples();
              if ($urandom_range(9) == 0) begin
                trend = TR_APPROACH;
                ramp  = $urandom_range(1, 200);
              end
            end
          endcase
          measure_run(amb, lit);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3)) send_frame(1'($urandom_range(1)), random_samples());
        end else if (pick < 93) begin
          send_frame(iratd_pkg::KIND_ON, random_samples());
        end else begin
          repeat (2) send_frame(iratd_pkg::KIND_OFF, random_samples());
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.kind       <= iratd_pkg::KIND_ON;
    in_bus.sample_ch1 <= '0;
    in_bus.sample_ch2 <= '0;
    in_bus.sample_ch3 <= '0;
    in_bus.sample_aux <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_approach_ramp();
    test_level_extremes();
    test_random_traffic();
    settle_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/iratd_pkg.sv
hw/rtl/iratd_if.sv
hw/rtl/iratd_hist_cell.sv
hw/rtl/iratd_hist_line.sv
hw/rtl/ir_proximity_ambient_trend_detect_top.sv
tb/testbench.sv
